// ===== hw/rtl/wmdc_pkg.sv =====
package wmdc_pkg;

   localparam int SIDES_MAX_DEF = 4;
   localparam int DUTY_MAX_DEF  = 4095;

   localparam logic [2:0] CMD_OPEN  = 3'd0;
   localparam logic [2:0] CMD_CLOSE = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_SPEED = 3'd3;
   localparam logic [2:0] CMD_TICK  = 3'd4;
   localparam logic [2:0] CMD_ALL   = 3'd5;

   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_OPEN  = 2'd1;
   localparam logic [1:0] DIR_CLOSE = 2'd2;

   localparam logic [2:0] WS_UNKNOWN = 3'd0;
   localparam logic [2:0] WS_OPENING = 3'd1;
   localparam logic [2:0] WS_CLOSING = 3'd2;
   localparam logic [2:0] WS_OPEN    = 3'd3;
   localparam logic [2:0] WS_CLOSED  = 3'd4;
   localparam logic [2:0] WS_STOPPED = 3'd5;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CFG     = 3'd1;
   localparam logic [2:0] ST_SPEED   = 3'd2;
   localparam logic [2:0] ST_ENDSTOP = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;

   localparam logic [2:0] EV_CMD      = 3'd1;
   localparam logic [2:0] EV_DEAD     = 3'd2;
   localparam logic [2:0] EV_ENDSTOP  = 3'd3;
   localparam logic [2:0] EV_PRESS    = 3'd4;
   localparam logic [2:0] EV_PRESSED  = 3'd5;
   localparam logic [2:0] EV_TIMEOUT  = 3'd6;

   localparam logic [2:0] REG_SIDE_EN  = 3'd0;
   localparam logic [2:0] REG_ES_EN    = 3'd1;
   localparam logic [2:0] REG_DEF_SPD  = 3'd2;
   localparam logic [2:0] REG_DEAD     = 3'd3;
   localparam logic [2:0] REG_POLL     = 3'd4;
   localparam logic [2:0] REG_MAX_OPEN = 3'd5;
   localparam logic [2:0] REG_MAX_CLS  = 3'd6;
   localparam logic [2:0] REG_PRESS    = 3'd7;

   typedef struct packed {
      logic [6:0]  runtime_speed;
      logic [1:0]  dir;
   } duty_req_type;

   function automatic logic [6:0] sat100(input logic [6:0] v);
      sat100 = (v > 7'd100) ? 7'd100 : v;
   endfunction

endpackage

// ===== hw/rtl/wmdc_duty.sv =====
module wmdc_duty
   import wmdc_pkg::*;
#(
   parameter int DUTY_MAX = DUTY_MAX_DEF
) (
   input  logic         clock,
   input  duty_req_type req,
   output logic [11:0]  open_duty,
   output logic [11:0]  close_duty
);
   localparam int PW = 7 + $clog2(DUTY_MAX + 1);
   localparam logic [PW-1:0] DMAX = PW'(DUTY_MAX);
   localparam int RW = PW + 18;
   localparam logic [17:0] RECIP = 18'd167772;

   logic [PW-1:0] prod_ff;
   logic [1:0]    dir_ff;
   logic [RW-1:0] approx;
   logic [PW-1:0] quot0, rem0, quot;

   // product registered, then divide by 100 via reciprocal with correction
   always_ff @(posedge clock) begin
      prod_ff <= PW'(sat100(req.runtime_speed)) * DMAX;
      dir_ff  <= req.dir;
   end

   always_comb begin
      approx = RW'(prod_ff) * RW'(RECIP);
      quot0  = PW'(approx >> 24);
      rem0   = prod_ff - PW'(quot0 * PW'(100));
      quot   = quot0;
      if (rem0 >= PW'(100)) quot = quot0 + PW'(1);
      if (rem0 >= PW'(200)) quot = quot0 + PW'(2);
      open_duty  = (dir_ff == DIR_OPEN)  ? quot[11:0] : 12'd0;
      close_duty = (dir_ff == DIR_CLOSE) ? quot[11:0] : 12'd0;
   end
endmodule

// ===== hw/rtl/window_motor_deadtime_controller_unit.sv =====
// sequence: a side command passes S_PASS, S_SCAN, then S_OUT, which steps over each lower side,
// and S_DUTY registers its result; stop-all takes the same path with a pass over every side;
// a tick adds S_POLL and, when the poll is due, a scan over every side; each further result
// goes back through S_OUT to the next side with an event and waits in S_DUTY on rsp_tready
// flow: one transaction at a time, req_tready only in idle
// reset: synchronous active high, configuration registers to defaults, no side moving, state unknown
module window_motor_deadtime_controller_unit
   import wmdc_pkg::*;
#(
   parameter int MAX_SIDES = SIDES_MAX_DEF,
   parameter int DUTY_MAX  = DUTY_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0] side[4:3] speed[11:5] speed_given[12] open_endstops[16:13]
   // close_endstops[20:17], zero fill
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_side[1:0] window_state[4:2] open_duty[16:5] close_duty[28:17]
   // status[31:29] event_res[34:32] side_moving[35] all_stopped[36], zero fill
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   localparam int NS = (MAX_SIDES < 4) ? MAX_SIDES : 4;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PASS = 3'd1;
   localparam logic [2:0] S_POLL = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DUTY = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [3:0]  side_en_ff, es_en_ff;
   logic [6:0]  def_spd_ff;
   logic [15:0] dead_cfg_ff, poll_cfg_ff, press_cfg_ff;
   logic [23:0] max_open_ff, max_cls_ff;

   logic [2:0]  sst_ff [4];
   logic [1:0]  act_ff [4];
   logic [1:0]  pend_ff[4];
   logic [15:0] dtr_ff [4];
   logic [23:0] mel_ff [4];
   logic        pra_ff [4];
   logic [15:0] pre_ff [4];
   logic [6:0]  rsp_ff [4];
   logic [6:0]  psp_ff [4];
   logic [15:0] poll_ff;

   logic [3:0]  hev_ff;
   logic [2:0]  ev_ff [4];
   logic [2:0]  stv_ff[4];

   logic [2:0]  state_ff;
   logic [1:0]  idx_ff;
   logic        pass_ff;
   logic        do_poll_ff;
   logic [23:0] item_ff;
   logic        ext_ff;

   logic [2:0]  cmd;
   logic [1:0]  side;
   logic [6:0]  spd;
   logic        spd_given;
   logic [3:0]  oes, ces;
   assign cmd       = item_ff[2:0];
   assign side      = item_ff[4:3];
   assign spd       = item_ff[11:5];
   assign spd_given = item_ff[12];
   assign oes       = item_ff[16:13];
   assign ces       = item_ff[20:17];

   function automatic logic on(input logic [3:0] m, input logic [1:0] i);
      on = (32'(i) < NS) && m[i];
   endfunction

   // shared per-side update unit, operates on side idx_ff
   logic [2:0]  u_sst;
   logic [1:0]  u_act, u_pend;
   logic [15:0] u_dtr, u_pre;
   logic [23:0] u_mel;
   logic        u_pra, u_ev;
   logic [6:0]  u_rsp, u_psp, u_sp;
   logic [2:0]  u_e, u_s;
   logic [1:0]  ui, u_dir;
   logic        u_hit, u_open;
   logic [23:0] u_lim;

   always_comb begin
      ui = idx_ff;
      u_sst = sst_ff[ui]; u_act = act_ff[ui]; u_pend = pend_ff[ui];
      u_dtr = dtr_ff[ui]; u_mel = mel_ff[ui]; u_pra = pra_ff[ui];
      u_pre = pre_ff[ui]; u_rsp = rsp_ff[ui]; u_psp = psp_ff[ui];
      u_ev = 1'b0; u_e = EV_CMD; u_s = ST_OK;
      u_sp = 7'd0; u_dir = DIR_NONE; u_open = 1'b0; u_hit = 1'b0; u_lim = 24'd0;
      if (state_ff == S_PASS && (cmd == CMD_OPEN || cmd == CMD_CLOSE ||
          cmd == CMD_STOP || cmd == CMD_SPEED)) begin
         if (!on(side_en_ff, ui)) begin
            u_ev = 1'b1; u_s = ST_CFG;
         end else if (cmd == CMD_STOP) begin
            u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
            u_pra = 1'b0; u_pre = 16'd0; u_mel = 24'd0; u_sst = WS_STOPPED;
            u_ev = 1'b1;
         end else if (cmd == CMD_SPEED) begin
            u_ev = 1'b1;
            if (!spd_given) u_s = ST_SPEED;
            else begin
               u_sp = sat100(spd);
               u_rsp = u_sp;
               if (u_pend != DIR_NONE) u_psp = u_sp;
               if (u_sp == 7'd0) begin
                  u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
                  u_pra = 1'b0; u_pre = 16'd0; u_mel = 24'd0; u_sst = WS_STOPPED;
               end
            end
         end else begin
            u_dir  = (cmd == CMD_OPEN) ? DIR_OPEN : DIR_CLOSE;
            u_open = (cmd == CMD_OPEN);
            u_sp = (u_rsp != 7'd0) ? u_rsp : sat100(def_spd_ff);
            if (u_pend != DIR_NONE && u_psp != 7'd0) u_sp = u_psp;
            if (spd_given) u_sp = sat100(spd);
            u_hit = es_en_ff[ui] && (u_open ? oes[ui] : ces[ui]);
            u_ev = 1'b1;
            if (u_sp == 7'd0) u_s = ST_SPEED;
            else if (u_hit && (u_open || press_cfg_ff == 16'd0)) begin
               u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
               u_pra = 1'b0; u_pre = 16'd0; u_mel = 24'd0;
               u_sst = u_open ? WS_OPEN : WS_CLOSED; u_s = ST_ENDSTOP;
            end else if (u_pend == u_dir) begin
               u_psp = u_sp; u_rsp = u_sp;
            end else begin
               if (u_pend != DIR_NONE) begin
                  u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
                  u_pra = 1'b0; u_pre = 16'd0; u_mel = 24'd0;
               end
               if (u_act == u_dir) u_rsp = u_sp;
               else begin
                  if (u_act != DIR_NONE) begin
                     u_act = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0; u_mel = 24'd0;
                  end
                  u_pra = 1'b0; u_pre = 16'd0;
                  u_pend = u_dir; u_psp = u_sp; u_dtr = dead_cfg_ff;
                  u_sst = u_open ? WS_OPENING : WS_CLOSING;
               end
            end
         end
      end else if (state_ff == S_PASS && cmd == CMD_ALL) begin
         if (on(side_en_ff, ui)) begin
            u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
            u_pra = 1'b0; u_pre = 16'd0; u_mel = 24'd0;
            if (u_sst == WS_OPENING || u_sst == WS_CLOSING) u_sst = WS_STOPPED;
            u_ev = 1'b1;
         end
      end else if (state_ff == S_PASS) begin
         // tick: counters, then dead-time expiry
         if (u_act != DIR_NONE && u_mel != 24'hFFFFFF) u_mel = u_mel + 24'd1;
         if (u_pra && u_pre != 16'hFFFF) u_pre = u_pre + 16'd1;
         if (u_pend != DIR_NONE && u_dtr != 16'd0) u_dtr = u_dtr - 16'd1;
         if (on(side_en_ff, ui) && u_pend != DIR_NONE && u_dtr == 16'd0) begin
            u_open = (u_pend == DIR_OPEN);
            u_hit  = es_en_ff[ui] && (u_open ? oes[ui] : ces[ui]);
            u_ev = 1'b1;
            if (u_hit && (u_open || press_cfg_ff == 16'd0)) begin
               u_pend = DIR_NONE; u_psp = 7'd0;
               u_sst = u_open ? WS_OPEN : WS_CLOSED;
               u_e = EV_ENDSTOP; u_s = ST_ENDSTOP;
            end else begin
               u_act = u_pend; u_rsp = u_psp; u_mel = 24'd0;
               u_pend = DIR_NONE; u_psp = 7'd0; u_e = EV_DEAD;
            end
         end
      end else if (state_ff == S_SCAN && do_poll_ff && on(side_en_ff, ui) &&
                   u_act != DIR_NONE) begin
         u_lim = (u_act == DIR_CLOSE) ? max_cls_ff : max_open_ff;
         if (u_pra) begin
            if (u_pre >= press_cfg_ff) begin
               u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
               u_pra = 1'b0; u_pre = 16'd0; u_mel = 24'd0; u_sst = WS_CLOSED;
               u_ev = 1'b1; u_e = EV_PRESSED;
            end
         end else if (u_act == DIR_OPEN && es_en_ff[ui] && oes[ui]) begin
            u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
            u_pre = 16'd0; u_mel = 24'd0; u_sst = WS_OPEN;
            u_ev = 1'b1; u_e = EV_ENDSTOP;
         end else if (u_act == DIR_CLOSE && es_en_ff[ui] && ces[ui]) begin
            u_ev = 1'b1;
            if (press_cfg_ff != 16'd0) begin
               u_pra = 1'b1; u_pre = 16'd0; u_e = EV_PRESS;
            end else begin
               u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
               u_pre = 16'd0; u_mel = 24'd0; u_sst = WS_CLOSED; u_e = EV_ENDSTOP;
            end
         end else if (u_lim != 24'd0 && u_mel >= u_lim) begin
            u_act = DIR_NONE; u_pend = DIR_NONE; u_psp = 7'd0; u_dtr = 16'd0;
            u_pre = 16'd0; u_mel = 24'd0; u_sst = WS_STOPPED;
            u_ev = 1'b1; u_e = EV_TIMEOUT; u_s = ST_TIMEOUT;
         end
      end
   end

   // output selection
   logic         all_stop, o_mv, more;
   logic [2:0]   o_sst;
   logic [1:0]   osel;
   duty_req_type dreq;
   logic [11:0]  od, cd;

   always_comb begin
      all_stop = 1'b1;
      for (int i = 0; i < NS; i++)
         if (side_en_ff[i] && (act_ff[i] != DIR_NONE || pend_ff[i] != DIR_NONE))
            all_stop = 1'b0;
      osel = idx_ff;
      more = 1'b0;
      for (int i = 0; i < 4; i++)
         if (32'(i) > 32'(idx_ff) && hev_ff[i]) more = 1'b1;
      o_sst = sst_ff[osel];
      o_mv  = act_ff[osel] != DIR_NONE || pend_ff[osel] != DIR_NONE;
      dreq.runtime_speed = rsp_ff[osel];
      dreq.dir = act_ff[osel];
      if (ext_ff) begin
         o_sst = WS_UNKNOWN; o_mv = 1'b0; dreq.dir = DIR_NONE;
      end
   end

   wmdc_duty #(.DUTY_MAX(DUTY_MAX)) u_duty (
      .clock(clock), .req(dreq), .open_duty(od), .close_duty(cd)
   );

   logic [39:0] rdata_ff;
   logic        rlast_ff, rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tlast  = rlast_ff;
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_en_ff <= 4'd0; es_en_ff <= 4'd0; def_spd_ff <= 7'd50;
         dead_cfg_ff <= 16'd100; poll_cfg_ff <= 16'd10;
         max_open_ff <= 24'd30000; max_cls_ff <= 24'd30000; press_cfg_ff <= 16'd0;
         for (int i = 0; i < 4; i++) begin
            sst_ff[i] <= WS_UNKNOWN; act_ff[i] <= DIR_NONE; pend_ff[i] <= DIR_NONE;
            dtr_ff[i] <= 16'd0; mel_ff[i] <= 24'd0; pra_ff[i] <= 1'b0;
            pre_ff[i] <= 16'd0; rsp_ff[i] <= 7'd0; psp_ff[i] <= 7'd0;
         end
         poll_ff <= 16'd0; hev_ff <= 4'd0; state_ff <= S_IDLE; idx_ff <= 2'd0;
         pass_ff <= 1'b0; do_poll_ff <= 1'b0; ext_ff <= 1'b0; rvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_SIDE_EN:  side_en_ff   <= csr_wdata[3:0];
               REG_ES_EN:    es_en_ff     <= csr_wdata[3:0];
               REG_DEF_SPD:  def_spd_ff   <= csr_wdata[6:0];
               REG_DEAD:     dead_cfg_ff  <= csr_wdata[15:0];
               REG_POLL:     poll_cfg_ff  <= csr_wdata[15:0];
               REG_MAX_OPEN: max_open_ff  <= csr_wdata;
               REG_MAX_CLS:  max_cls_ff   <= csr_wdata;
               REG_PRESS:    press_cfg_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (u_ev) begin
            hev_ff[idx_ff] <= 1'b1; ev_ff[idx_ff] <= u_e; stv_ff[idx_ff] <= u_s;
         end
         if (state_ff == S_PASS || state_ff == S_SCAN) begin
            sst_ff[idx_ff] <= u_sst; act_ff[idx_ff] <= u_act; pend_ff[idx_ff] <= u_pend;
            dtr_ff[idx_ff] <= u_dtr; mel_ff[idx_ff] <= u_mel; pra_ff[idx_ff] <= u_pra;
            pre_ff[idx_ff] <= u_pre; rsp_ff[idx_ff] <= u_rsp; psp_ff[idx_ff] <= u_psp;
         end
         if (rvalid_ff && rsp_tready && state_ff != S_DUTY) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               hev_ff <= 4'd0;
               if (req_tvalid) begin
                  item_ff <= req_tdata;
                  if (req_tdata[2:0] <= CMD_SPEED) begin
                     idx_ff <= req_tdata[4:3];
                     pass_ff <= 1'b1;
                     if (32'(req_tdata[4:3]) >= NS) begin
                        ext_ff <= 1'b1; state_ff <= S_DUTY;
                     end else begin
                        ext_ff <= 1'b0; state_ff <= S_PASS;
                     end
                  end else if (req_tdata[2:0] == CMD_TICK ||
                               req_tdata[2:0] == CMD_ALL) begin
                     idx_ff <= 2'd0; pass_ff <= 1'b0; ext_ff <= 1'b0; state_ff <= S_PASS;
                  end
               end
            end
            S_PASS: begin
               if (pass_ff || 32'(idx_ff) == NS - 1) begin
                  idx_ff <= 2'd0;
                  state_ff <= (cmd == CMD_TICK) ? S_POLL : S_SCAN;
                  do_poll_ff <= 1'b0;
               end else idx_ff <= idx_ff + 2'd1;
            end
            S_POLL: begin
               if (poll_ff != 16'hFFFF && poll_ff + 16'd1 >= poll_cfg_ff) begin
                  poll_ff <= 16'd0; do_poll_ff <= 1'b1;
               end else if (poll_ff == 16'hFFFF && poll_ff >= poll_cfg_ff) begin
                  poll_ff <= 16'd0; do_poll_ff <= 1'b1;
               end else if (poll_ff != 16'hFFFF) poll_ff <= poll_ff + 16'd1;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // scan walks the sides only on a tick with a due poll; otherwise it resets idx for S_OUT
               if (cmd == CMD_TICK && do_poll_ff && 32'(idx_ff) != NS - 1)
                  idx_ff <= idx_ff + 2'd1;
               else begin
                  do_poll_ff <= 1'b0;
                  idx_ff <= 2'd0;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // advance idx to next side with an event
               if (hev_ff[idx_ff]) state_ff <= S_DUTY;
               else if (more) idx_ff <= idx_ff + 2'd1;
               else state_ff <= S_IDLE;
            end
            S_DUTY: begin
               if (!rvalid_ff || rsp_tready) begin
                  rvalid_ff <= 1'b1;
                  rdata_ff  <= {3'd0, all_stop, o_mv,
                                ext_ff ? EV_CMD : ev_ff[idx_ff],
                                ext_ff ? ST_CFG : stv_ff[idx_ff],
                                ext_ff ? 12'd0 : cd, ext_ff ? 12'd0 : od, o_sst, idx_ff};
                  rlast_ff  <= ext_ff || !more;
                  if (ext_ff || !more) state_ff <= S_IDLE;
                  else begin
                     idx_ff <= idx_ff + 2'd1; state_ff <= S_OUT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
